[src/tsan_pkg.sv]
// Shared types and constants for the packet timestamp sanitizer.
package tsan_pkg;

  localparam int TS_W = 64;

  typedef logic signed [TS_W-1:0] ts_t;

  // Most negative value marks an absent timestamp.
  localparam ts_t TS_NONE = {1'b1, {(TS_W-1){1'b0}}};
  localparam ts_t TS_ZERO = '0;
  localparam ts_t TS_ONE  = {{(TS_W-1){1'b0}}, 1'b1};

  typedef enum logic {
    MODE_VIDEO = 1'b0,
    MODE_AUDIO = 1'b1
  } mode_t;

  typedef enum logic {
    CFG_STRICT_INCREASE    = 1'b0,
    CFG_DROP_AUDIO_PREROLL = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic strict_increase;
    logic drop_audio_preroll;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    ts_t   pts;
    ts_t   dts;
  } item_t;

  // Last dts per stream kind, each with its successor kept alongside.
  typedef struct packed {
    ts_t  last_audio;
    ts_t  last_audio_p1;
    ts_t  last_video;
    ts_t  last_video_p1;
    ts_t  preroll_stamp;
    logic preroll_armed;
  } state_t;

  typedef struct packed {
    logic  keep;
    mode_t kind;
    ts_t   fixed_pts;
    ts_t   fixed_dts;
  } result_t;

endpackage

[src/tsan_fix.sv]
// Single-pass timestamp correction: preroll filter, median fix, dts clamp.
module tsan_fix (
  input  tsan_pkg::item_t   item,
  input  tsan_pkg::state_t  st,
  input  tsan_pkg::cfg_t    cfg,
  output tsan_pkg::result_t res,
  output tsan_pkg::state_t  st_nxt
);

  logic           audio_beat;
  tsan_pkg::ts_t  p;
  tsan_pkg::ts_t  d;
  tsan_pkg::ts_t  last;
  tsan_pkg::ts_t  last_p1;
  tsan_pkg::ts_t  last_p2;
  tsan_pkg::ts_t  floor_ts;
  tsan_pkg::ts_t  floor_p1;
  tsan_pkg::ts_t  p_p1;
  tsan_pkg::ts_t  d_p1;
  tsan_pkg::ts_t  pre_eff;
  tsan_pkg::ts_t  med;
  tsan_pkg::ts_t  med_p1;
  tsan_pkg::ts_t  p1;
  tsan_pkg::ts_t  d1;
  tsan_pkg::ts_t  d1_p1;
  tsan_pkg::ts_t  p2;
  tsan_pkg::ts_t  d2;
  tsan_pkg::ts_t  d2_p1;
  logic           drop;
  logic           fix_med;
  logic           raise_en;
  logic           below;

  always_comb begin
    audio_beat = (item.mode == tsan_pkg::MODE_AUDIO);
    p          = item.pts;
    d          = item.dts;
    last       = audio_beat ? st.last_audio    : st.last_video;
    last_p1    = audio_beat ? st.last_audio_p1 : st.last_video_p1;

    // Successors of every candidate dts, computed in parallel.
    last_p2  = last_p1 + tsan_pkg::TS_ONE;
    p_p1     = p + tsan_pkg::TS_ONE;
    d_p1     = d + tsan_pkg::TS_ONE;

    floor_ts = cfg.strict_increase ? last_p1 : last;
    floor_p1 = cfg.strict_increase ? last_p2 : last_p1;

    // Preroll: the capture is visible to the match in the same beat.
    pre_eff  = st.preroll_armed ? p : st.preroll_stamp;
    drop     = audio_beat && cfg.drop_audio_preroll &&
               (p != tsan_pkg::TS_ZERO) && (p == pre_eff);

    // Median of pts, dts and last + 1 when dts runs ahead of pts.
    fix_med  = (p != tsan_pkg::TS_NONE) && (d != tsan_pkg::TS_NONE) &&
               ($signed(d) > $signed(p));
    if ($signed(last_p1) <= $signed(p)) begin
      med    = p;
      med_p1 = p_p1;
    end else if ($signed(last_p1) >= $signed(d)) begin
      med    = d;
      med_p1 = d_p1;
    end else begin
      med    = last_p1;
      med_p1 = last_p2;
    end
    p1    = fix_med ? med : p;
    d1    = fix_med ? med : d;
    d1_p1 = fix_med ? med_p1 : d_p1;

    // Clamp dts to the floor; video clamps only after a median fix.
    raise_en = audio_beat ? ((d1 != tsan_pkg::TS_NONE) && (last != tsan_pkg::TS_NONE))
                          : fix_med;
    below    = raise_en && ($signed(d1) < $signed(floor_ts));
    p2       = (below && ($signed(p1) >= $signed(d1)) &&
                ($signed(p1) < $signed(floor_ts))) ? floor_ts : p1;
    d2       = below ? floor_ts : d1;
    d2_p1    = below ? floor_p1 : d1_p1;

    res.keep      = !drop;
    res.kind      = item.mode;
    res.fixed_pts = p2;
    res.fixed_dts = d2;

    st_nxt = st;
    if (audio_beat && cfg.drop_audio_preroll && st.preroll_armed) begin
      st_nxt.preroll_stamp = p;
      st_nxt.preroll_armed = (p == tsan_pkg::TS_NONE);
    end
    if (!drop) begin
      if (audio_beat) begin
        st_nxt.last_audio    = d2;
        st_nxt.last_audio_p1 = d2_p1;
      end else begin
        st_nxt.last_video    = d2;
        st_nxt.last_video_p1 = d2_p1;
      end
    end
  end

endmodule

[src/packet_timestamp_sanitizer_unit.sv]
// Top level of the packet timestamp sanitizer: input stage, state and result register.
// A taken beat sits in the input register until the result register is free or drains
// (a dropped beat gives no result beat). Throughput: one beat per cycle unless out_ready
// stalls; each stream's last dts updates as a beat leaves, in time for the next beat.
// Reset (rst_n low, synchronous): both channels empty, strict_increase = 1,
// drop_audio_preroll = 0, last dts of both streams absent, preroll armed.
module packet_timestamp_sanitizer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic signed [63:0]   in_pts,
  input  logic signed [63:0]   in_dts,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic signed [63:0]   out_fixed_pts,
  output logic signed [63:0]   out_fixed_dts,
  // configuration writes
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_wdata
);

  tsan_pkg::cfg_t    cfg_r;
  tsan_pkg::state_t  st_r;
  tsan_pkg::state_t  st_nxt;
  tsan_pkg::item_t   in_item;
  tsan_pkg::item_t   s1_item_r;
  logic              s1_valid_r;
  tsan_pkg::result_t res;
  logic              out_valid_r;
  logic              out_kind_r;
  tsan_pkg::ts_t     out_pts_r;
  tsan_pkg::ts_t     out_dts_r;
  logic              adv;

  assign in_item.mode = tsan_pkg::mode_t'(in_mode);
  assign in_item.pts  = in_pts;
  assign in_item.dts  = in_dts;

  // Advance the held beat whenever the result register is free or drains.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  tsan_fix u_fix (
    .item   (s1_item_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .res    (res),
    .st_nxt (st_nxt)
  );

  // Configuration registers: written only while the block is idle (user rule, unchecked).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strict_increase    <= 1'b1;
      cfg_r.drop_audio_preroll <= 1'b0;
    end else if (cfg_we) begin
      unique case (tsan_pkg::cfg_idx_t'(cfg_index))
        tsan_pkg::CFG_STRICT_INCREASE:    cfg_r.strict_increase    <= cfg_wdata;
        tsan_pkg::CFG_DROP_AUDIO_PREROLL: cfg_r.drop_audio_preroll <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control and per-stream state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      st_r.last_audio     <= tsan_pkg::TS_NONE;
      st_r.last_audio_p1  <= tsan_pkg::TS_NONE + tsan_pkg::TS_ONE;
      st_r.last_video     <= tsan_pkg::TS_NONE;
      st_r.last_video_p1  <= tsan_pkg::TS_NONE + tsan_pkg::TS_ONE;
      st_r.preroll_stamp  <= tsan_pkg::TS_ZERO;
      st_r.preroll_armed  <= 1'b1;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        st_r        <= st_nxt;
        out_valid_r <= res.keep;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture on accept, load the result on advance.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (adv && res.keep) begin
      out_kind_r <= res.kind;
      out_pts_r  <= res.fixed_pts;
      out_dts_r  <= res.fixed_dts;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_fixed_pts = out_pts_r;
  assign out_fixed_dts = out_dts_r;

`ifndef NO_ASSERTIONS
  a_audio_p1: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.last_audio_p1 == st_r.last_audio + tsan_pkg::TS_ONE)
    else $error("audio last dts successor out of step");

  a_video_p1: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.last_video_p1 == st_r.last_video + tsan_pkg::TS_ONE)
    else $error("video last dts successor out of step");

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !res.keep |=> !out_valid_r)
    else $error("dropped beat produced a result");

  a_last_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.keep && (res.kind == tsan_pkg::MODE_AUDIO)
    |=> st_r.last_audio == out_dts_r)
    else $error("audio last dts differs from delivered dts");
`endif

endmodule

[test/tb_packet_timestamp_sanitizer_unit.sv]
// Self-checking testbench for the packet timestamp sanitizer: directed and random packets.
module tb_packet_timestamp_sanitizer_unit;

  localparam tsan_pkg::ts_t TS_MAX = {1'b0, {(tsan_pkg::TS_W-1){1'b1}}};
  // Audio pts that the preroll capture locks onto in the directed preroll sequence.
  localparam tsan_pkg::ts_t PREROLL_PTS = 64'sd1000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid  = 1'b0;
  logic          in_ready;
  logic          in_mode   = 1'b0;
  tsan_pkg::ts_t in_pts    = '0;
  tsan_pkg::ts_t in_dts    = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          out_kind;
  tsan_pkg::ts_t out_fixed_pts;
  tsan_pkg::ts_t out_fixed_dts;
  logic          cfg_we    = 1'b0;
  logic          cfg_index = 1'b0;
  logic          cfg_wdata = 1'b0;

  packet_timestamp_sanitizer_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_pts        (in_pts),
    .in_dts        (in_dts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_fixed_pts (out_fixed_pts),
    .out_fixed_dts (out_fixed_dts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Packets waiting to be driven, and the corrected stamps still owed by the block.
  tsan_pkg::item_t   packets_pending[$];
  tsan_pkg::result_t stamps_due[$];

  // Shadow of the block: register settings and per-stream history.
  logic          strict_q        = 1'b1;
  logic          drop_preroll_q  = 1'b0;
  tsan_pkg::ts_t last_audio_q    = tsan_pkg::TS_NONE;
  tsan_pkg::ts_t last_video_q    = tsan_pkg::TS_NONE;
  tsan_pkg::ts_t preroll_stamp_q = tsan_pkg::TS_ZERO;
  logic          preroll_armed_q = 1'b1;

  // Running stream positions used to build plausible random sequences.
  tsan_pkg::ts_t audio_base = '0;
  tsan_pkg::ts_t video_base = '0;

  int issued_cnt   = 0;
  int accepted_cnt = 0;
  int audio_cnt    = 0;
  int repaired_cnt = 0;
  int dropped_cnt  = 0;
  int result_cnt   = 0;
  int mismatches   = 0;

  // Sender pacing.
  int   burst_left = 8;
  int   gap_left   = 0;
  logic drain_hold = 1'b0;

  // Receiver stall pattern.
  int       recv_cycle = 0;
  int       stall_left = 0;
  logic [1:0] recv_mode = 2'd0;

  tsan_pkg::result_t due;

  // Median of pts, dts and last + 1, given pts < dts; the sum wraps like a plain adder.
  function automatic tsan_pkg::ts_t median_of_three(input tsan_pkg::ts_t pts,
                                                    input tsan_pkg::ts_t dts,
                                                    input tsan_pkg::ts_t last);
    tsan_pkg::ts_t next;
    next = last + tsan_pkg::TS_ONE;
    if (next <= pts) return pts;
    if (next >= dts) return dts;
    return next;
  endfunction

  // Raise dts to last (+1 when strict); carry pts along only if it sat in [dts, bound).
  function automatic void lift_to_bound(inout tsan_pkg::ts_t pts, inout tsan_pkg::ts_t dts,
                                        input tsan_pkg::ts_t last);
    tsan_pkg::ts_t bound;
    bound = strict_q ? last + tsan_pkg::TS_ONE : last;
    if (dts < bound) begin
      if (pts >= dts && pts < bound) pts = bound;
      dts = bound;
    end
  endfunction

  // Work out the corrected stamps for one accepted packet; keep = 0 means it is swallowed.
  function automatic tsan_pkg::result_t sanitize_packet(input tsan_pkg::item_t pkt);
    tsan_pkg::result_t res;
    tsan_pkg::ts_t     p;
    tsan_pkg::ts_t     d;
    logic              both;
    p        = pkt.pts;
    d        = pkt.dts;
    both     = (p != tsan_pkg::TS_NONE) && (d != tsan_pkg::TS_NONE);
    res.keep = 1'b1;
    res.kind = pkt.mode;
    if (pkt.mode == tsan_pkg::MODE_AUDIO) begin
      if (drop_preroll_q) begin
        // Capture the first audio pts; stay armed only while it is absent.
        if (preroll_armed_q) begin
          preroll_stamp_q = p;
          preroll_armed_q = (p == tsan_pkg::TS_NONE);
        end
        if (p != tsan_pkg::TS_ZERO && p == preroll_stamp_q) begin
          res.keep      = 1'b0;
          res.fixed_pts = p;
          res.fixed_dts = d;
          return res;
        end
      end
      if (both && d > p) begin
        p = median_of_three(p, d, last_audio_q);
        d = p;
      end
      // An absent last dts skips the raise on the audio side.
      if (d != tsan_pkg::TS_NONE && last_audio_q != tsan_pkg::TS_NONE)
        lift_to_bound(p, d, last_audio_q);
      last_audio_q = d;
    end else begin
      // Video raises only inside the reorder fix, using the sentinel as a number.
      if (both && d > p) begin
        p = median_of_three(p, d, last_video_q);
        d = p;
        lift_to_bound(p, d, last_video_q);
      end
      last_video_q = d;
    end
    res.fixed_pts = p;
    res.fixed_dts = d;
    return res;
  endfunction

  function automatic tsan_pkg::ts_t random_stamp();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed streams: slowly advancing stamps with jitter, with occasional
  // jumps backward, runs near both ends of the range, absent stamps and pure noise.
  function automatic tsan_pkg::item_t random_packet();
    tsan_pkg::item_t pkt;
    tsan_pkg::ts_t   base;
    int unsigned     roll;
    pkt.mode = $urandom_range(0, 1) ? tsan_pkg::MODE_AUDIO : tsan_pkg::MODE_VIDEO;
    base     = (pkt.mode == tsan_pkg::MODE_AUDIO) ? audio_base : video_base;
    roll     = $urandom_range(0, 99);
    if (roll < 3)       base = random_stamp();
    else if (roll < 5)  base = TS_MAX - $urandom_range(0, 20);
    else if (roll < 7)  base = tsan_pkg::TS_NONE + $urandom_range(1, 20);
    else if (roll < 13) base = base - $urandom_range(1, 30);
    else                base = base + $urandom_range(0, 3);
    pkt.pts = base + $urandom_range(0, 12) - 4;
    pkt.dts = base + $urandom_range(0, 8) - 4;
    roll = $urandom_range(0, 99);
    if (roll < 6)       pkt.pts = tsan_pkg::TS_NONE;
    else if (roll < 12) pkt.dts = tsan_pkg::TS_NONE;
    else if (roll < 16) pkt.pts = random_stamp();
    else if (roll < 20) pkt.dts = random_stamp();
    else if (roll < 22) pkt.pts = tsan_pkg::TS_ZERO;
    else if (roll < 32 && pkt.mode == tsan_pkg::MODE_AUDIO) pkt.pts = PREROLL_PTS;
    if (pkt.mode == tsan_pkg::MODE_AUDIO) audio_base = base;
    else                                  video_base = base;
    return pkt;
  endfunction

  task automatic queue_packet(input tsan_pkg::mode_t mode, input tsan_pkg::ts_t pts,
                              input tsan_pkg::ts_t dts);
    tsan_pkg::item_t pkt;
    pkt.mode = mode;
    pkt.pts  = pts;
    pkt.dts  = dts;
    packets_pending.push_back(pkt);
    issued_cnt++;
  endtask

  task automatic queue_random(input int count);
    repeat (count) begin
      packets_pending.push_back(random_packet());
      issued_cnt++;
    end
  endtask

  // Hold until every queued packet is taken and every owed result is back, then let
  // a swallowed beat still in the pipe drain out.
  task automatic wait_quiet();
    while (accepted_cnt != issued_cnt || stamps_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input tsan_pkg::cfg_idx_t idx, input logic value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == tsan_pkg::CFG_STRICT_INCREASE) strict_q       = value;
    else                                      drop_preroll_q = value;
  endtask

  // Driver: predict each beat as it is taken, then offer the next one when the slot is free.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tsan_pkg::item_t   taken;
        tsan_pkg::result_t fix;
        taken.mode = tsan_pkg::mode_t'(in_mode);
        taken.pts  = in_pts;
        taken.dts  = in_dts;
        fix = sanitize_packet(taken);
        accepted_cnt++;
        if (taken.mode == tsan_pkg::MODE_AUDIO) audio_cnt++;
        if (fix.keep) begin
          stamps_due.push_back(fix);
          if (fix.fixed_pts != taken.pts || fix.fixed_dts != taken.dts) repaired_cnt++;
        end else begin
          dropped_cnt++;
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (drain_hold) begin
          // Pause the sender until every owed result has come back.
          if (stamps_due.size() == 0) drain_hold = 1'b0;
          in_valid <= 1'b0;
        end else if (packets_pending.size() != 0) begin
          tsan_pkg::item_t nxt;
          nxt = packets_pending.pop_front();
          in_valid <= 1'b1;
          in_mode  <= nxt.mode;
          in_pts   <= nxt.pts;
          in_dts   <= nxt.dts;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            drain_hold = ($urandom_range(0, 19) == 0);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest owed result, then pick the
  // ready level for the next cycle from the current stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_cnt++;
        if (stamps_due.size() == 0) begin
          $error("result beat with nothing owed: kind %0d pts %0d dts %0d",
                 out_kind, out_fixed_pts, out_fixed_dts);
          mismatches++;
        end else begin
          due = stamps_due.pop_front();
          if (out_kind !== due.kind) begin
            $error("kind mismatch: expected %0d, got %0d", due.kind, out_kind);
            mismatches++;
          end
          if (out_fixed_pts !== due.fixed_pts) begin
            $error("fixed_pts mismatch: expected %0d, got %0d",
                   due.fixed_pts, out_fixed_pts);
            mismatches++;
          end
          if (out_fixed_dts !== due.fixed_dts) begin
            $error("fixed_dts mismatch: expected %0d, got %0d",
                   due.fixed_dts, out_fixed_dts);
            mismatches++;
          end
        end
      end
      recv_cycle++;
      if (recv_cycle % 64 == 0) recv_mode = 2'($urandom_range(0, 3));
      case (recv_mode)
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= 1'($urandom_range(0, 1));
        2'd2: out_ready <= (recv_cycle % 4 == 0);
        default: begin
          // Long stalls now and then, otherwise ready.
          if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(3, 12);
          end
        end
      endcase
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: strict increase, no preroll filtering.
    // Video: reorder fix with absent history, absent stamps, extremes, wrap of last + 1.
    queue_packet(tsan_pkg::MODE_VIDEO, 64'sd10, 64'sd20);
    queue_packet(tsan_pkg::MODE_VIDEO, tsan_pkg::TS_NONE, 64'sd5);
    queue_packet(tsan_pkg::MODE_VIDEO, 64'sd3, tsan_pkg::TS_NONE);
    queue_packet(tsan_pkg::MODE_VIDEO, TS_MAX, TS_MAX);
    queue_packet(tsan_pkg::MODE_VIDEO, 64'sd0, 64'sd100);
    queue_packet(tsan_pkg::MODE_VIDEO, -64'sd1, -64'sd1);
    queue_packet(tsan_pkg::MODE_VIDEO, tsan_pkg::TS_NONE + tsan_pkg::TS_ONE, TS_MAX);
    // Audio: skip the raise with no history, raise pts along, absent pts while raising.
    queue_packet(tsan_pkg::MODE_AUDIO, tsan_pkg::TS_NONE, tsan_pkg::TS_NONE);
    queue_packet(tsan_pkg::MODE_AUDIO, 64'sd50, 64'sd40);
    queue_packet(tsan_pkg::MODE_AUDIO, 64'sd30, 64'sd35);
    queue_packet(tsan_pkg::MODE_AUDIO, tsan_pkg::TS_NONE, 64'sd10);
    queue_packet(tsan_pkg::MODE_AUDIO, -64'sd1, 64'sd0);
    queue_packet(tsan_pkg::MODE_AUDIO, TS_MAX, TS_MAX);
    queue_packet(tsan_pkg::MODE_AUDIO, 64'sd5, 64'sd7);
    queue_packet(tsan_pkg::MODE_AUDIO, tsan_pkg::TS_NONE + tsan_pkg::TS_ONE,
                 tsan_pkg::TS_NONE + tsan_pkg::TS_ONE);
    queue_packet(tsan_pkg::MODE_AUDIO, TS_MAX, tsan_pkg::TS_NONE);
    queue_random(240);

    // Equal dts allowed.
    wait_quiet();
    write_reg(tsan_pkg::CFG_STRICT_INCREASE, 1'b0);
    write_reg(tsan_pkg::CFG_DROP_AUDIO_PREROLL, 1'b0);
    queue_random(240);

    // Preroll filtering on: absent pts keeps the capture armed, then lock onto a stamp
    // and swallow it and its repeats; zero and other stamps pass.
    wait_quiet();
    write_reg(tsan_pkg::CFG_STRICT_INCREASE, 1'b1);
    write_reg(tsan_pkg::CFG_DROP_AUDIO_PREROLL, 1'b1);
    queue_packet(tsan_pkg::MODE_VIDEO, PREROLL_PTS, PREROLL_PTS);
    queue_packet(tsan_pkg::MODE_AUDIO, tsan_pkg::TS_NONE, 64'sd900);
    queue_packet(tsan_pkg::MODE_AUDIO, PREROLL_PTS, PREROLL_PTS - 2);
    queue_packet(tsan_pkg::MODE_AUDIO, PREROLL_PTS, PREROLL_PTS);
    queue_packet(tsan_pkg::MODE_AUDIO, tsan_pkg::TS_ZERO, tsan_pkg::TS_ZERO);
    queue_packet(tsan_pkg::MODE_AUDIO, PREROLL_PTS + 1, PREROLL_PTS + 1);
    queue_packet(tsan_pkg::MODE_AUDIO, tsan_pkg::TS_NONE, tsan_pkg::TS_NONE);
    queue_packet(tsan_pkg::MODE_AUDIO, PREROLL_PTS, tsan_pkg::TS_NONE);
    queue_random(240);

    wait_quiet();
    write_reg(tsan_pkg::CFG_STRICT_INCREASE, 1'b0);
    queue_random(240);

    wait_quiet();
    write_reg(tsan_pkg::CFG_STRICT_INCREASE, 1'b1);
    write_reg(tsan_pkg::CFG_DROP_AUDIO_PREROLL, 1'b0);
    queue_random(240);

    wait_quiet();
    repeat (8) @(posedge clk);
    $display("covered %0d packets (%0d audio) across five configuration phases:",
             accepted_cnt, audio_cnt);
    $display("  %0d result beats, %0d with repaired stamps, %0d swallowed as preroll",
             result_cnt, repaired_cnt, dropped_cnt);
    if (mismatches == 0 && stamps_due.size() == 0) begin
      $display("[packet_timestamp_sanitizer_unit] OK");
    end else begin
      $display("[packet_timestamp_sanitizer_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("[packet_timestamp_sanitizer_unit] ERROR");
    $finish;
  end

endmodule

[sim.f]
src/tsan_pkg.sv
src/tsan_fix.sv
src/packet_timestamp_sanitizer_unit.sv
test/tb_packet_timestamp_sanitizer_unit.sv
